// ===== rtl/pcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Types, widths and codes shared by the permutation pair cycle compare block.
// ----------------------------------------------------------------------------
package pcc_pkg;

  // Default number of positions held in the stores.
  localparam int PCC_MAX_LEN = 16;

  // Entry values and positions taking part in the cycle walk.
  localparam int VAL_W = 4;
  // Largest pair length that can still be a permutation of 4-bit values.
  localparam int PERM_LIMIT = 1 << VAL_W;
  // Cycle count width; holds PERM_LIMIT itself.
  localparam int CNT_W = 5;
  localparam int ERR_W = 2;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_NOT_PERM = 2'd2
  } err_code_t;

  typedef enum logic {
    TS_LOAD,
    TS_WALK
  } top_state_t;

  typedef enum logic [1:0] {
    WK_IDLE,
    WK_SCAN,
    WK_FETCH_FIRST,
    WK_FETCH_SECOND
  } walk_state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
  } walk_cmd_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] cycles;
  } walk_status_t;

endpackage

// ===== rtl/pcc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_if
// Valid/ready channels: one permutation position in, one result out.
// ----------------------------------------------------------------------------
interface pcc_in_if;
  import pcc_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] first_entry;
  logic [VAL_W-1:0] second_entry;
  logic             last_entry;

  modport source (output valid, first_entry, second_entry, last_entry, input ready);
  modport sink (input valid, first_entry, second_entry, last_entry, output ready);
endinterface

interface pcc_out_if;
  import pcc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] cycle_count;
  logic [VAL_W-1:0] swap_low;
  logic [VAL_W-1:0] swap_high;
  logic [ERR_W-1:0] error_code;

  modport source (output valid, cycle_count, swap_low, swap_high, error_code, input ready);
  modport sink (input valid, cycle_count, swap_low, swap_high, error_code, output ready);
endinterface

// ===== rtl/pcc_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_store
// Entry memories for both permutations, one write and one registered read each.
// ----------------------------------------------------------------------------
module pcc_store #(
  parameter int DEPTH = pcc_pkg::PCC_MAX_LEN,
  parameter int AW    = 4
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [pcc_pkg::VAL_W-1:0] wr_first,
  input  logic [pcc_pkg::VAL_W-1:0] wr_second,
  input  logic [AW-1:0]           first_addr,
  input  logic [AW-1:0]           second_addr,
  output logic [pcc_pkg::VAL_W-1:0] first_data,
  output logic [pcc_pkg::VAL_W-1:0] second_data
);
  import pcc_pkg::*;

  logic [VAL_W-1:0] first_mem  [DEPTH];
  logic [VAL_W-1:0] second_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      first_mem[wr_addr]  <= wr_first;
      second_mem[wr_addr] <= wr_second;
    end
    first_data  <= first_mem[first_addr];
    second_data <= second_mem[second_addr];
  end

endmodule

// ===== rtl/pcc_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_walk
// Cycle walk sequencer: follows k -> second[first[k]] through the stores and
// counts the cycles of the composed map.
// ----------------------------------------------------------------------------
module pcc_walk #(
  parameter int AW = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pcc_pkg::walk_cmd_t        cmd,
  output pcc_pkg::walk_status_t     status,
  output logic [AW-1:0]             first_addr,
  output logic [AW-1:0]             second_addr,
  input  logic [pcc_pkg::VAL_W-1:0] first_data,
  input  logic [pcc_pkg::VAL_W-1:0] second_data
);
  import pcc_pkg::*;

  walk_state_t           state;
  walk_state_t           state_next;
  logic [CNT_W-1:0]      k;
  logic [CNT_W-1:0]      n;
  logic [CNT_W-1:0]      cycles;
  logic [PERM_LIMIT-1:0] visited;
  logic [VAL_W-1:0]      idx_k;
  logic                  scan_end;
  logic                  hit_k;
  logic                  hit_j;

  assign idx_k    = k[VAL_W-1:0];
  assign scan_end = (k == n);
  assign hit_k    = visited[idx_k];
  assign hit_j    = visited[second_data];

  always_comb begin
    state_next = state;
    unique case (state)
      WK_IDLE: begin
        if (cmd.start) state_next = WK_SCAN;
      end
      WK_SCAN: begin
        if (scan_end) state_next = WK_IDLE;
        else if (!hit_k) state_next = WK_FETCH_FIRST;
      end
      WK_FETCH_FIRST: state_next = WK_FETCH_SECOND;
      WK_FETCH_SECOND: begin
        state_next = hit_j ? WK_SCAN : WK_FETCH_FIRST;
      end
      default: state_next = WK_IDLE;
    endcase
  end

  always_comb begin
    first_addr    = '0;
    second_addr   = '0;
    status.done   = 1'b0;
    status.cycles = cycles;
    unique case (state)
      WK_IDLE: ;
      WK_SCAN: begin
        if (scan_end) status.done = 1'b1;
        else first_addr = AW'(idx_k);
      end
      WK_FETCH_FIRST: second_addr = AW'(first_data);
      WK_FETCH_SECOND: first_addr = AW'(second_data);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= WK_IDLE;
      k       <= '0;
      n       <= '0;
      cycles  <= '0;
      visited <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        WK_IDLE: begin
          if (cmd.start) begin
            k       <= '0;
            n       <= cmd.n;
            cycles  <= '0;
            visited <= '0;
          end
        end
        WK_SCAN: begin
          if (!scan_end) begin
            if (hit_k) begin
              k <= k + 1'b1;
            end else begin
              // open a new cycle at k
              cycles         <= cycles + 1'b1;
              visited[idx_k] <= 1'b1;
            end
          end
        end
        WK_FETCH_FIRST: ;
        WK_FETCH_SECOND: begin
          // back at a visited position: the cycle is closed
          if (hit_j) k <= k + 1'b1;
          else visited[second_data] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/permutation_pair_cycle_compare.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_pair_cycle_compare
// Loads two permutations position by position, then counts the cycles of
// k -> second[first[k]] and reports where the two permutations differ.
// ----------------------------------------------------------------------------
// A new position can be loaded as soon as the last one is taken. An item
// marked last with an error (too many entries, or not a permutation) raises
// its result in the cycle after it is taken. Otherwise the cycle walk runs:
// one scan step per position, two dependent store lookups per position
// (first, then second, each through a registered memory read) and one
// closing scan step; the result is registered when the closing step ends it.
// The input is held not ready during the walk and while an untaken result
// blocks the next.
// ----------------------------------------------------------------------------
module permutation_pair_cycle_compare #(
  parameter int MAX_LEN = pcc_pkg::PCC_MAX_LEN
) (
  input  logic      clk,
  input  logic      rst,
  pcc_in_if.sink    entries,
  pcc_out_if.source result
);
  import pcc_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  top_state_t            state;
  top_state_t            state_next;
  logic [CW-1:0]         entry_count;
  logic [PERM_LIMIT-1:0] first_seen;
  logic [PERM_LIMIT-1:0] second_seen;
  logic [1:0]            diff_count;
  logic [VAL_W-1:0]      diff_pos_a;
  logic [VAL_W-1:0]      diff_pos_b;
  logic                  overflow;
  logic                  out_valid;
  logic [CNT_W-1:0]      cycle_count;
  logic [VAL_W-1:0]      swap_low;
  logic [VAL_W-1:0]      swap_high;
  err_code_t             error_code;

  logic                  accept;
  logic                  slot_free;
  logic                  has_room;
  logic                  differ;
  logic [CW-1:0]         count_eff;
  logic                  overflow_eff;
  logic [PERM_LIMIT-1:0] first_seen_eff;
  logic [PERM_LIMIT-1:0] second_seen_eff;
  logic [1:0]            diff_count_eff;
  logic [VAL_W-1:0]      pos_cur;
  logic [VAL_W-1:0]      pos_a_eff;
  logic [VAL_W-1:0]      pos_b_eff;
  logic [CNT_W-1:0]      n_low;
  logic [PERM_LIMIT:0]   full_wide;
  logic [PERM_LIMIT-1:0] full_mask;
  err_code_t             err_eff;
  logic [VAL_W-1:0]      lo_eff;
  logic [VAL_W-1:0]      hi_eff;

  walk_cmd_t             walk_cmd;
  walk_status_t          walk_status;
  logic [AW-1:0]         first_addr;
  logic [AW-1:0]         second_addr;
  logic [VAL_W-1:0]      first_data;
  logic [VAL_W-1:0]      second_data;

  assign slot_free = !out_valid || result.ready;
  assign accept    = entries.valid && entries.ready;

  // Bookkeeping as it stands once the current transfer is counted.
  always_comb begin
    has_room        = 32'(entry_count) < MAX_LEN;
    count_eff       = entry_count + CW'(has_room);
    overflow_eff    = overflow || !has_room;
    first_seen_eff  = first_seen;
    second_seen_eff = second_seen;
    if (has_room) begin
      first_seen_eff  = first_seen | (PERM_LIMIT'(1) << entries.first_entry);
      second_seen_eff = second_seen | (PERM_LIMIT'(1) << entries.second_entry);
    end
    differ         = has_room && (entries.first_entry != entries.second_entry);
    pos_cur        = VAL_W'(entry_count);
    diff_count_eff = diff_count;
    if (differ && diff_count != 2'd3) diff_count_eff = diff_count + 2'd1;
    pos_a_eff = (differ && diff_count_eff == 2'd1) ? pos_cur : diff_pos_a;
    pos_b_eff = (differ && diff_count_eff == 2'd2) ? pos_cur : diff_pos_b;

    n_low     = CNT_W'(count_eff);
    full_wide = ((PERM_LIMIT + 1)'(1) << n_low) - (PERM_LIMIT + 1)'(1);
    full_mask = full_wide[PERM_LIMIT-1:0];

    priority if (overflow_eff) begin
      err_eff = ERR_OVERFLOW;
    end else if (32'(count_eff) > PERM_LIMIT) begin
      err_eff = ERR_NOT_PERM;
    end else if (first_seen_eff != full_mask || second_seen_eff != full_mask) begin
      err_eff = ERR_NOT_PERM;
    end else begin
      err_eff = ERR_OK;
    end

    lo_eff = '0;
    hi_eff = '0;
    if (err_eff == ERR_OK && diff_count_eff != 2'd3) begin
      lo_eff = (pos_a_eff < pos_b_eff) ? pos_a_eff : pos_b_eff;
      hi_eff = (pos_a_eff < pos_b_eff) ? pos_b_eff : pos_a_eff;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      TS_LOAD: begin
        if (walk_cmd.start) state_next = TS_WALK;
      end
      TS_WALK: begin
        if (walk_status.done) state_next = TS_LOAD;
      end
      default: state_next = TS_LOAD;
    endcase
  end

  always_comb begin
    entries.ready = 1'b0;
    unique case (state)
      TS_LOAD: entries.ready = slot_free;
      TS_WALK: entries.ready = 1'b0;
      default: entries.ready = 1'b0;
    endcase
    walk_cmd.start = accept && entries.last_entry && (err_eff == ERR_OK);
    walk_cmd.n     = n_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= TS_LOAD;
      entry_count <= '0;
      first_seen  <= '0;
      second_seen <= '0;
      diff_count  <= '0;
      diff_pos_a  <= '0;
      diff_pos_b  <= '0;
      overflow    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      // raise on an error result or a finished walk, drop once taken
      if ((accept && entries.last_entry && err_eff != ERR_OK) ||
          (state == TS_WALK && walk_status.done)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (entries.last_entry) begin
          // close the pair and start clean for the next one
          entry_count <= '0;
          first_seen  <= '0;
          second_seen <= '0;
          diff_count  <= '0;
          diff_pos_a  <= '0;
          diff_pos_b  <= '0;
          overflow    <= 1'b0;
        end else begin
          entry_count <= count_eff;
          first_seen  <= first_seen_eff;
          second_seen <= second_seen_eff;
          diff_count  <= diff_count_eff;
          diff_pos_a  <= pos_a_eff;
          diff_pos_b  <= pos_b_eff;
          overflow    <= overflow_eff;
        end
      end
    end
  end

  // Result payload; the cycle count lands when the walk finishes.
  always_ff @(posedge clk) begin
    if (accept && entries.last_entry) begin
      cycle_count <= '0;
      swap_low    <= lo_eff;
      swap_high   <= hi_eff;
      error_code  <= err_eff;
    end
    if (state == TS_WALK && walk_status.done) cycle_count <= walk_status.cycles;
  end

  assign result.valid       = out_valid;
  assign result.cycle_count = cycle_count;
  assign result.swap_low    = swap_low;
  assign result.swap_high   = swap_high;
  assign result.error_code  = error_code;

  pcc_store #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_store (
    .clk         (clk),
    .wr_en       (accept && has_room),
    .wr_addr     (AW'(entry_count)),
    .wr_first    (entries.first_entry),
    .wr_second   (entries.second_entry),
    .first_addr  (first_addr),
    .second_addr (second_addr),
    .first_data  (first_data),
    .second_data (second_data)
  );

  pcc_walk #(
    .AW (AW)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (walk_cmd),
    .status      (walk_status),
    .first_addr  (first_addr),
    .second_addr (second_addr),
    .first_data  (first_data),
    .second_data (second_data)
  );

endmodule

// ===== rtl/pcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks for the permutation pair cycle compare block.
// ----------------------------------------------------------------------------
module pcc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [pcc_pkg::CNT_W-1:0] cycle_count,
  input logic [pcc_pkg::VAL_W-1:0] swap_low,
  input logic [pcc_pkg::VAL_W-1:0] swap_high,
  input logic [pcc_pkg::ERR_W-1:0] error_code
);
  import pcc_pkg::*;

  // A stalled result blocks new input transfers.
  a_in_blocked : assert property (@(posedge clk) disable iff (rst)
    (in_ready && out_valid) |-> out_ready)
    else $error("input taken while result stalled");

  a_err_fields : assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_OK) |->
      (cycle_count == '0 && swap_low == '0 && swap_high == '0 &&
       (error_code == ERR_OVERFLOW || error_code == ERR_NOT_PERM)))
    else $error("error result carries nonzero fields");

  a_ok_fields : assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == ERR_OK) |->
      (cycle_count != '0 && cycle_count <= CNT_W'(PERM_LIMIT) && swap_low <= swap_high))
    else $error("good result out of range");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(cycle_count) && $stable(swap_low) &&
       $stable(swap_high) && $stable(error_code)))
    else $error("stalled result changed");

endmodule

bind permutation_pair_cycle_compare pcc_checker u_pcc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (entries.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .cycle_count (result.cycle_count),
  .swap_low    (result.swap_low),
  .swap_high   (result.swap_high),
  .error_code  (result.error_code)
);

// ===== bench/pcc_cycle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_cycle_checker
// Watches both channels of the permutation pair cycle compare block. For
// every accepted position it updates its own copy of the pair state; on a
// position marked last it works out the cycle count, the differing positions
// and the error code, and checks them against the next accepted result.
// ----------------------------------------------------------------------------
module pcc_cycle_checker
  import pcc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pcc_in_if    entries,
  pcc_out_if   result,
  output int   mismatches,
  output int   pending
);

  localparam int STORE_DEPTH = PCC_MAX_LEN;

  typedef struct packed {
    logic [CNT_W-1:0] cycles;
    logic [VAL_W-1:0] swap_lo;
    logic [VAL_W-1:0] swap_hi;
    err_code_t        err;
  } pair_outcome_t;

  logic [VAL_W-1:0] pair_first  [STORE_DEPTH];
  logic [VAL_W-1:0] pair_second [STORE_DEPTH];
  logic [15:0]      first_seen;
  logic [15:0]      second_seen;
  int               loaded;
  int               diff_tally;
  logic [VAL_W-1:0] diff_pos_a;
  logic [VAL_W-1:0] diff_pos_b;
  logic             too_long;

  pair_outcome_t    expected_outcomes [$];

  function automatic void clear_pair();
    first_seen  = '0;
    second_seen = '0;
    loaded      = 0;
    diff_tally  = 0;
    diff_pos_a  = '0;
    diff_pos_b  = '0;
    too_long    = 1'b0;
  endfunction

  // Only called once both sequences are known permutations of 0..n-1.
  function automatic logic [CNT_W-1:0] count_composed_cycles(int n);
    logic [15:0] seen;
    int          cycles;
    int          j;
    seen   = '0;
    cycles = 0;
    for (int k = 0; k < n; k++) begin
      if (!seen[k]) begin
        cycles++;
        j = k;
        while (!seen[j]) begin
          seen[j] = 1'b1;
          j = pair_second[pair_first[j]];
        end
      end
    end
    return CNT_W'(cycles);
  endfunction

  function automatic void absorb_position(logic [VAL_W-1:0] f, logic [VAL_W-1:0] s,
                                          logic fin);
    pair_outcome_t v;
    logic [15:0]   full;
    if (loaded < STORE_DEPTH) begin
      pair_first[loaded]  = f;
      pair_second[loaded] = s;
      first_seen[f]       = 1'b1;
      second_seen[s]      = 1'b1;
      if (f != s) begin
        if (diff_tally < 3) diff_tally++;
        if (diff_tally == 1) diff_pos_a = VAL_W'(loaded);
        else if (diff_tally == 2) diff_pos_b = VAL_W'(loaded);
      end
      loaded++;
    end else begin
      too_long = 1'b1;
    end
    if (!fin) return;

    v.cycles  = '0;
    v.swap_lo = '0;
    v.swap_hi = '0;
    v.err     = ERR_OK;
    full = (loaded >= 16) ? 16'hFFFF : 16'((32'd1 << loaded) - 1);
    if (too_long) begin
      v.err = ERR_OVERFLOW;
    end else if (first_seen != full || second_seen != full) begin
      v.err = ERR_NOT_PERM;
    end else begin
      v.cycles = count_composed_cycles(loaded);
      // a single difference pairs with position 0
      if (diff_tally <= 2) begin
        v.swap_lo = (diff_pos_a < diff_pos_b) ? diff_pos_a : diff_pos_b;
        v.swap_hi = (diff_pos_a < diff_pos_b) ? diff_pos_b : diff_pos_a;
      end
    end
    expected_outcomes.push_back(v);
    clear_pair();
  endfunction

  function automatic int field_differs(string field, logic [7:0] want, logic [7:0] got);
    if (got === want) return 0;
    $error("%s: expected %0d, got %0d", field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    pair_outcome_t want;
    if (rst) begin
      clear_pair();
      expected_outcomes.delete();
    end else begin
      if (entries.valid && entries.ready) begin
        absorb_position(entries.first_entry, entries.second_entry, entries.last_entry);
      end
      if (result.valid && result.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result transfer with no pair outstanding: cycle_count %0d, error_code %0d",
                 result.cycle_count, result.error_code);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          mismatches += field_differs("cycle_count", 8'(want.cycles), 8'(result.cycle_count));
          mismatches += field_differs("swap_low", 8'(want.swap_lo), 8'(result.swap_low));
          mismatches += field_differs("swap_high", 8'(want.swap_hi), 8'(result.swap_high));
          mismatches += field_differs("error_code", 8'(want.err), 8'(result.error_code));
        end
      end
    end
    pending <= expected_outcomes.size();
  end

endmodule

// ===== bench/permutation_pair_cycle_compare_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_pair_cycle_compare_test
// Feeds permutation pairs position by position: a few hand-picked pairs, then
// random well-formed pairs (same, one swap, three moved, unrelated) mixed with
// corrupted, random and overlong sequences. Both channels stall in random
// bursts; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module permutation_pair_cycle_compare_test;
  import pcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1350;
  localparam int CALM_TAIL   = 200;
  localparam int SEQ_DEPTH   = 24;

  typedef logic [15:0][VAL_W-1:0] perm_vec_t;

  logic clk = 1'b0;
  logic rst;

  pcc_in_if  entries_if ();
  pcc_out_if result_if ();

  int mismatches;
  int pending;
  int cycle_no;
  int positions_sent;
  int pairs_sent;
  int overlong_pairs;
  int full_pairs;
  int ready_hold;
  bit idle_on;

  logic [VAL_W-1:0] first_seq  [SEQ_DEPTH];
  logic [VAL_W-1:0] second_seq [SEQ_DEPTH];

  always #4 clk = ~clk;

  permutation_pair_cycle_compare u_dut (
    .clk     (clk),
    .rst     (rst),
    .entries (entries_if),
    .result  (result_if)
  );

  pcc_cycle_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .entries    (entries_if),
    .result     (result_if),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Result side: hold ready low in bursts of random length.
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      ready_hold      <= 0;
    end else if (ready_hold > 0) begin
      ready_hold      <= ready_hold - 1;
      result_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      result_if.ready <= 1'b0;
      ready_hold      <= $urandom_range(0, 9);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("permutation_pair_cycle_compare_test: errors");
      $finish;
    end
  end

  function automatic perm_vec_t random_perm(int len);
    perm_vec_t        p;
    logic [VAL_W-1:0] t;
    int               j;
    for (int i = 0; i < 16; i++) p[i] = VAL_W'(i);
    for (int i = len - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = p[i];
      p[i] = p[j];
      p[j] = t;
    end
    return p;
  endfunction

  task automatic send_position(input logic [VAL_W-1:0] f, input logic [VAL_W-1:0] s,
                               input logic fin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      entries_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    entries_if.valid        <= 1'b1;
    entries_if.first_entry  <= f;
    entries_if.second_entry <= s;
    entries_if.last_entry   <= fin;
    @(posedge clk);
    while (!entries_if.ready) @(posedge clk);
    positions_sent++;
  endtask

  task automatic send_pair(input int len);
    for (int i = 0; i < len; i++) send_position(first_seq[i], second_seq[i], i == len - 1);
    pairs_sent++;
  endtask

  // Position 0 sits in the lowest nibble.
  task automatic send_packed(input perm_vec_t a, input perm_vec_t b, input int len);
    for (int i = 0; i < 16; i++) begin
      first_seq[i]  = a[i];
      second_seq[i] = b[i];
    end
    send_pair(len);
  endtask

  initial begin
    perm_vec_t        pa;
    perm_vec_t        pb;
    logic [VAL_W-1:0] t;
    int               len;
    int               kind;
    int               x;
    int               y;
    int               z;

    rst                     = 1'b1;
    entries_if.valid        = 1'b0;
    entries_if.first_entry  = '0;
    entries_if.second_entry = '0;
    entries_if.last_entry   = 1'b0;
    idle_on                 = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_packed(64'h0, 64'h0, 1);           // single position
    send_packed(64'h10, 64'h01, 2);         // smallest swap
    send_packed(64'h100, 64'h012, 3);       // repeated value in first
    send_packed(64'h210, 64'h01F, 3);       // value 15 in a short pair
    send_packed(64'h3210, 64'h2210, 4);     // one difference, second broken
    send_packed(64'h3210, 64'h0123, 4);     // every position differs
    send_packed(64'h01234, 64'h31204, 5);   // differences at 1 and 4

    while (positions_sent < ITEM_TARGET) begin
      idle_on = (positions_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 15);
      len     = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      pa      = random_perm(len);
      pb      = pa;
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          if (len >= 2) begin
            x = $urandom_range(0, len - 1);
            do y = $urandom_range(0, len - 1); while (y == x);
            pb[x] = pa[y];
            pb[y] = pa[x];
          end
        end
        2: pb = random_perm(len);
        default: begin
          if (len >= 3) begin
            x = $urandom_range(0, len - 3);
            y = $urandom_range(x + 1, len - 2);
            z = $urandom_range(y + 1, len - 1);
            t     = pb[x];
            pb[x] = pb[y];
            pb[y] = pb[z];
            pb[z] = t;
          end
        end
      endcase

      if (kind >= 10 && kind <= 12) begin
        // corrupt one entry of either sequence
        x = $urandom_range(0, len - 1);
        if ($urandom_range(0, 1) == 0) pa[x] = VAL_W'($urandom_range(0, 15));
        else pb[x] = VAL_W'($urandom_range(0, 15));
      end

      if (kind == 13) begin
        len = $urandom_range(17, 20);
        for (int i = 0; i < len; i++) begin
          first_seq[i]  = VAL_W'(i);
          second_seq[i] = ($urandom_range(0, 1) == 0) ? VAL_W'(i) : VAL_W'($urandom_range(0, 15));
        end
        overlong_pairs++;
        send_pair(len);
      end else if (kind >= 14) begin
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) begin
          first_seq[i]  = VAL_W'($urandom_range(0, 15));
          second_seq[i] = VAL_W'($urandom_range(0, 15));
        end
        send_pair(len);
      end else begin
        if (len == 16) full_pairs++;
        send_packed(pa, pb, len);
      end
    end

    idle_on = 1'b0;
    entries_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);

    $display("covered %0d positions in %0d pairs: %0d full-length, %0d over the store depth",
             positions_sent, pairs_sent, full_pairs, overlong_pairs);
    if (mismatches == 0) begin
      $display("permutation_pair_cycle_compare_test: clean");
    end else begin
      $display("permutation_pair_cycle_compare_test: errors");
    end
    $finish;
  end

endmodule
